// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk_i, muted while reset is active.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising edge of clk_i, muted while reset is active.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every rising edge of clk_i.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/uib_pkg.sv =====
// ----------------------------------------------------------------------------
// UART interrupt byte buffers package
// Action and status codes and the input item type.
// ----------------------------------------------------------------------------
package uib_pkg;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_GET   = 2'd1,
    ACT_IRQ   = 2'd2,
    ACT_FLUSH = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TX_FULL  = 2'd1,
    ST_RX_EMPTY = 2'd2,
    ST_BUSY     = 2'd3
  } status_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] write_byte;
    logic       rx_ready;
    logic       tx_ready;
    logic [7:0] rx_byte;
  } item_t;

endpackage

// ===== hw/rtl/uart_interrupt_byte_buffers.sv =====
// ----------------------------------------------------------------------------
// UART interrupt byte buffers
// Transmit and receive byte rings with interrupt enable bookkeeping.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   --------  ------------------------  -----------------------------------------
//   input     in_valid_i / in_ready_o   action, write_byte, rx_ready, tx_ready,
//                                       rx_byte
//   output    out_valid_o / out_ready_i status, read_byte, send_strobe, send_byte,
//                                       tx_irq_armed, rx_irq_armed
//
// One item per cycle is sustained while results are taken; each item passes
// from input transfer to result through the input register and the result register.
// Each ring RAM is read continuously at the next tail, so the byte an item
// pops is ready when the item reaches the input register.
// Reset empties both rings, clears the transmit enable and sets the receive
// enable; ring contents are not cleared. A stalled result holds the item in the
// input register and drops in_ready_o.
`include "assert_macros.svh"

module uart_interrupt_byte_buffers #(
  parameter int RING_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] write_byte_i,
  input  logic       rx_ready_i,
  input  logic       tx_ready_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] read_byte_o,
  output logic       send_strobe_o,
  output logic [7:0] send_byte_o,
  output logic       tx_irq_armed_o,
  output logic       rx_irq_armed_o
);
  import uib_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LastSlot = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(RING_DEPTH);
  localparam logic [CW-1:0] AlmostFull = CW'(RING_DEPTH - 1);

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
    logic [AW-1:0] nxt;
    nxt = (idx == LastSlot) ? '0 : idx + AW'(1);
    return nxt;
  endfunction

  item_t           item_q;
  logic            item_valid_q, item_valid_d;
  logic            in_xfer, advance;

  logic [AW-1:0]   tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [AW-1:0]   rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [CW-1:0]   tx_count_q, tx_count_d, rx_count_q, rx_count_d;
  logic            tx_en_q, tx_en_d, rx_en_q, rx_en_d;

  logic            tx_we, rx_we;
  logic [7:0]      tx_ram_rdata, rx_ram_rdata, tx_rd, rx_rd;
  logic            tx_fwd_q, tx_fwd_d, rx_fwd_q, rx_fwd_d;
  logic [7:0]      tx_fwd_data_q, rx_fwd_data_q;

  status_e         status;
  logic [7:0]      got, sent;
  logic            strobe, do_rx, do_tx;

  logic            out_valid_q, out_valid_d;
  status_e         status_q;
  logic [7:0]      read_byte_q, send_byte_q;
  logic            send_strobe_q, tx_armed_q, rx_armed_q;

  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  // A write to the slot being read this cycle would be missed by the read-first RAM.
  assign tx_rd = tx_fwd_q ? tx_fwd_data_q : tx_ram_rdata;
  assign rx_rd = rx_fwd_q ? rx_fwd_data_q : rx_ram_rdata;

  always_comb begin
    tx_head_d  = tx_head_q;
    tx_tail_d  = tx_tail_q;
    tx_count_d = tx_count_q;
    rx_head_d  = rx_head_q;
    rx_tail_d  = rx_tail_q;
    rx_count_d = rx_count_q;
    tx_en_d    = tx_en_q;
    rx_en_d    = rx_en_q;
    tx_we      = 1'b0;
    rx_we      = 1'b0;
    status     = ST_OK;
    got        = '0;
    sent       = '0;
    strobe     = 1'b0;
    do_rx      = item_q.rx_ready && (rx_count_q != FullCount);
    do_tx      = item_q.tx_ready && (tx_count_q != '0);
    if (advance) begin
      case (item_q.action)
        ACT_PUT: begin
          if (tx_count_q == FullCount) begin
            status = ST_TX_FULL;
          end else begin
            if (tx_count_q == '0) begin
              tx_en_d = 1'b1;
            end
            tx_we      = 1'b1;
            tx_head_d  = next_slot(tx_head_q);
            tx_count_d = tx_count_q + CW'(1);
          end
        end
        ACT_GET: begin
          if (rx_count_q == '0) begin
            status = ST_RX_EMPTY;
          end else begin
            if (rx_count_q == FullCount) begin
              rx_en_d = 1'b1;
            end
            got        = rx_rd;
            rx_tail_d  = next_slot(rx_tail_q);
            rx_count_d = rx_count_q - CW'(1);
          end
        end
        ACT_IRQ: begin
          if (do_rx) begin
            if (rx_count_q == AlmostFull) begin
              rx_en_d = 1'b0;
            end
            rx_we      = 1'b1;
            rx_head_d  = next_slot(rx_head_q);
            rx_count_d = rx_count_q + CW'(1);
          end
          if (do_tx) begin
            if (tx_count_q == CW'(1)) begin
              tx_en_d = 1'b0;
            end
            sent       = tx_rd;
            strobe     = 1'b1;
            tx_tail_d  = next_slot(tx_tail_q);
            tx_count_d = tx_count_q - CW'(1);
          end
        end
        ACT_FLUSH: begin
          if (tx_count_q != '0) begin
            status = ST_BUSY;
          end else begin
            tx_head_d  = '0;
            tx_tail_d  = '0;
            tx_count_d = '0;
            rx_head_d  = '0;
            rx_tail_d  = '0;
            rx_count_d = '0;
            tx_en_d    = 1'b0;
            rx_en_d    = 1'b0;
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end
  end

  assign tx_fwd_d = tx_we && (tx_head_q == tx_tail_d);
  assign rx_fwd_d = rx_we && (rx_head_q == rx_tail_d);

  uib_ram #(
    .Width(8),
    .Depth(RING_DEPTH)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (tx_we),
    .waddr_i(tx_head_q),
    .wdata_i(item_q.write_byte),
    .raddr_i(tx_tail_d),
    .rdata_o(tx_ram_rdata)
  );

  uib_ram #(
    .Width(8),
    .Depth(RING_DEPTH)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (rx_we),
    .waddr_i(rx_head_q),
    .wdata_i(item_q.rx_byte),
    .raddr_i(rx_tail_d),
    .rdata_o(rx_ram_rdata)
  );

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_xfer) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      tx_head_q    <= '0;
      tx_tail_q    <= '0;
      tx_count_q   <= '0;
      rx_head_q    <= '0;
      rx_tail_q    <= '0;
      rx_count_q   <= '0;
      tx_en_q      <= 1'b0;
      rx_en_q      <= 1'b1;
      tx_fwd_q     <= 1'b0;
      rx_fwd_q     <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
      tx_head_q    <= tx_head_d;
      tx_tail_q    <= tx_tail_d;
      tx_count_q   <= tx_count_d;
      rx_head_q    <= rx_head_d;
      rx_tail_q    <= rx_tail_d;
      rx_count_q   <= rx_count_d;
      tx_en_q      <= tx_en_d;
      rx_en_q      <= rx_en_d;
      tx_fwd_q     <= tx_fwd_d;
      rx_fwd_q     <= rx_fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_fwd_data_q <= item_q.write_byte;
    rx_fwd_data_q <= item_q.rx_byte;
    if (in_xfer) begin
      item_q.action     <= action_e'(action_i);
      item_q.write_byte <= write_byte_i;
      item_q.rx_ready   <= rx_ready_i;
      item_q.tx_ready   <= tx_ready_i;
      item_q.rx_byte    <= rx_byte_i;
    end
    if (advance) begin
      status_q      <= status;
      read_byte_q   <= got;
      send_strobe_q <= strobe;
      send_byte_q   <= sent;
      tx_armed_q    <= tx_en_d;
      rx_armed_q    <= rx_en_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign read_byte_o    = read_byte_q;
  assign send_strobe_o  = send_strobe_q;
  assign send_byte_o    = send_byte_q;
  assign tx_irq_armed_o = tx_armed_q;
  assign rx_irq_armed_o = rx_armed_q;

  `ASSERT_CLK(a_counts_bounded, (tx_count_q <= FullCount) && (rx_count_q <= FullCount), "ring count above depth")
  `ASSERT_IMPL(a_tx_empty_ptrs, tx_count_q == '0, tx_head_q == tx_tail_q, "empty transmit ring with pointers apart")
  `ASSERT_IMPL(a_rx_empty_ptrs, rx_count_q == '0, rx_head_q == rx_tail_q, "empty receive ring with pointers apart")
  `ASSERT_NEXT(a_flush_clears, advance && (item_q.action == ACT_FLUSH) && (tx_count_q == '0), (rx_count_q == '0) && !rx_en_q && !tx_en_q, "flush left state behind")

endmodule

// ===== hw/rtl/uib_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, read-first read data.
// ----------------------------------------------------------------------------
module uib_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
